FILE: src/ptb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and codes for the periodic / timeout timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

   // request kinds
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // configuration register indexes
   localparam logic REG_PERIODIC_IN_USE = 1'b0;
   localparam logic REG_TIMEOUT_IN_USE  = 1'b1;

   // width of the in-use registers
   localparam int USE_WIDTH = 4;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;     // latch the accepted request
      logic execute;     // apply start / stop to the addressed slot
      logic scan_issue;  // read the next slot of the tick walk
      logic publish;     // load the response register
   } ctl_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic is_tick;     // latched request is a tick
      logic scan_last;   // current read is the last slot
      logic rsp_busy;    // response register holds an untaken response
   } ctl_status_type;

endpackage

FILE: src/ptb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_req_if / ptb_rsp_if
// Valid/ready channels carrying timer-bank requests and responses.
// ----------------------------------------------------------------------------
interface ptb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        bank;
   logic [2:0]  slot;
   logic [15:0] load_value;

   modport source (output valid, output kind, output bank, output slot,
                   output load_value, input ready);
   modport sink   (input valid, input kind, input bank, input slot,
                   input load_value, output ready);
endinterface

interface ptb_rsp_if;
   logic       valid;
   logic       ready;
   logic       slot_active;
   logic       slot_finished;
   logic [7:0] periodic_done_mask;
   logic [7:0] timeout_done_mask;

   modport source (output valid, output slot_active, output slot_finished,
                   output periodic_done_mask, output timeout_done_mask, input ready);
   modport sink   (input valid, input slot_active, input slot_finished,
                   input periodic_done_mask, input timeout_done_mask, output ready);
endinterface

FILE: src/ptb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer for the timer bank: takes a request, runs it, hands off result.
// ----------------------------------------------------------------------------
module ptb_ctrl
   import ptb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output ctl_cmd_type    cmd,
   input  ctl_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.is_tick ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands decoded from state
   assign req_ready          = (state_ff == ST_IDLE);
   assign cmd.capture        = (state_ff == ST_IDLE) && req_valid;
   assign cmd.execute        = (state_ff == ST_EXEC) && !status.is_tick;
   assign cmd.scan_issue     = (state_ff == ST_SCAN);
   assign cmd.publish        = (state_ff == ST_FINISH) && !status.rsp_busy;

endmodule

FILE: src/ptb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_datapath
// Slot storage, shared decrementer for the tick walk, and response register.
// ----------------------------------------------------------------------------
module ptb_datapath
   import ptb_pkg::*;
#(
   parameter int PERIODIC_SLOTS = 8,
   parameter int TIMEOUT_SLOTS  = 8,
   parameter int COUNT_WIDTH    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   output ctl_status_type       status,
   input  logic [1:0]           req_kind,
   input  logic                 req_bank,
   input  logic [2:0]           req_slot,
   input  logic [15:0]          req_load_value,
   input  logic [USE_WIDTH-1:0] periodic_in_use,
   input  logic [USE_WIDTH-1:0] timeout_in_use,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_slot_active,
   output logic                 rsp_slot_finished,
   output logic [7:0]           rsp_periodic_done_mask,
   output logic [7:0]           rsp_timeout_done_mask
);

   localparam int TOTAL = PERIODIC_SLOTS + TIMEOUT_SLOTS;
   localparam int IDXW  = $clog2(TOTAL);
   localparam int PW    = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
   localparam int CMPW  = 7;

   // latched request
   kind_type               kind_ff;
   logic                   bank_ff;
   logic [2:0]             slot_ff;
   logic [COUNT_WIDTH-1:0] load_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_kind);
         bank_ff <= req_bank;
         slot_ff <= req_slot;
         load_ff <= COUNT_WIDTH'(req_load_value);
      end
   end

   // slot decode
   logic [CMPW-1:0]  bank_size;
   logic             slot_ok;
   logic [CMPW-1:0]  slot_k;
   logic [IDXW-1:0]  slot_idx;
   logic [PW-1:0]    slot_pidx;
   logic [CMPW-1:0]  slot_ext;
   logic [TOTAL-1:0] sel_vec;

   always_comb begin
      slot_ext  = CMPW'(slot_ff);
      bank_size = bank_ff ? CMPW'(TIMEOUT_SLOTS) : CMPW'(PERIODIC_SLOTS);
      slot_ok   = slot_ext < bank_size;
      slot_k    = (bank_ff ? CMPW'(PERIODIC_SLOTS) : CMPW'(0)) + slot_ext;
      slot_idx  = slot_k[IDXW-1:0];
      slot_pidx = slot_ext[PW-1:0];
      for (int i = 0; i < TOTAL; i++) begin
         sel_vec[i] = slot_ok && (slot_k == CMPW'(i));
      end
   end

   // tick walk pipeline: read one slot, update it the next cycle
   logic [IDXW-1:0] rd_idx_ff;
   logic [IDXW-1:0] upd_idx_ff;
   logic            upd_valid_ff;
   logic [PW-1:0]   per_raddr;

   assign per_raddr = (CMPW'(rd_idx_ff) < CMPW'(PERIODIC_SLOTS)) ? rd_idx_ff[PW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_valid_ff <= 1'b0;
      end else begin
         upd_valid_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_idx_ff <= '0;
      end else if (cmd.scan_issue) begin
         rd_idx_ff <= rd_idx_ff + IDXW'(1);
      end
      if (cmd.scan_issue) begin
         upd_idx_ff <= rd_idx_ff;
      end
   end

   // count and period memories
   logic [COUNT_WIDTH-1:0] cnt_mem [TOTAL];
   logic [COUNT_WIDTH-1:0] per_mem [PERIODIC_SLOTS];
   logic [COUNT_WIDTH-1:0] cnt_rdata_ff;
   logic [COUNT_WIDTH-1:0] per_rdata_ff;

   logic                   cnt_we;
   logic [IDXW-1:0]        cnt_waddr;
   logic [COUNT_WIDTH-1:0] cnt_wdata;
   logic                   per_we;

   // slot flags
   logic [TOTAL-1:0] active_ff;
   logic [TOTAL-1:0] active_in;
   logic [TOTAL-1:0] finished_ff;
   logic [TOTAL-1:0] finished_in;
   logic [TOTAL-1:0] clr_vec;
   logic             do_clear;

   // decrement of the slot under update
   logic                   upd_is_per;
   logic                   upd_in_use;
   logic                   upd_go;
   logic [COUNT_WIDTH-1:0] dec;
   logic                   hit;
   logic                   do_start;

   always_comb begin
      upd_is_per = CMPW'(upd_idx_ff) < CMPW'(PERIODIC_SLOTS);
      if (upd_is_per) begin
         upd_in_use = CMPW'(upd_idx_ff) < CMPW'(periodic_in_use);
      end else begin
         upd_in_use = (CMPW'(upd_idx_ff) - CMPW'(PERIODIC_SLOTS)) < CMPW'(timeout_in_use);
      end
      upd_go   = upd_valid_ff && upd_in_use && active_ff[upd_idx_ff];
      dec      = cnt_rdata_ff - COUNT_WIDTH'(1);
      hit      = (dec == '0);
      do_start = cmd.execute && slot_ok && (kind_ff == KIND_START);
   end

   // memory write port: start wins, else tick update
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = upd_idx_ff;
      cnt_wdata = (hit && upd_is_per) ? per_rdata_ff : dec;
      if (do_start) begin
         cnt_we    = 1'b1;
         cnt_waddr = slot_idx;
         cnt_wdata = load_ff;
      end else if (upd_go) begin
         cnt_we = 1'b1;
      end
      per_we = do_start && !bank_ff;
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (per_we) begin
         per_mem[slot_pidx] <= load_ff;
      end
      if (cmd.scan_issue) begin
         cnt_rdata_ff <= cnt_mem[rd_idx_ff];
         per_rdata_ff <= per_mem[per_raddr];
      end
   end

   // flag next state
   always_comb begin
      do_clear    = cmd.publish && (kind_ff == KIND_CLEAR);
      clr_vec     = do_clear ? sel_vec : '0;
      active_in   = active_ff;
      finished_in = finished_ff;
      if (cmd.execute && (kind_ff == KIND_START)) begin
         active_in   = active_ff | sel_vec;
         finished_in = finished_ff & ~sel_vec;
      end else if (cmd.execute && (kind_ff == KIND_STOP)) begin
         active_in = active_ff & ~sel_vec;
      end
      if (upd_go && hit) begin
         finished_in[upd_idx_ff] = 1'b1;
         if (!upd_is_per) active_in[upd_idx_ff] = 1'b0;
      end
      finished_in = finished_in & ~clr_vec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         finished_ff <= '0;
      end else begin
         active_ff   <= active_in;
         finished_ff <= finished_in;
      end
   end

   // response register
   logic [TOTAL-1:0] fin_after;
   logic [7:0]       pmask;
   logic [7:0]       tmask;

   always_comb begin
      fin_after = finished_ff & ~clr_vec;
      pmask     = '0;
      tmask     = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < PERIODIC_SLOTS) pmask[i] = fin_after[i];
         if (i < TIMEOUT_SLOTS)  tmask[i] = fin_after[PERIODIC_SLOTS + i];
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_slot_active        <= |(active_ff & sel_vec);
         rsp_slot_finished      <= |(finished_ff & sel_vec);
         rsp_periodic_done_mask <= pmask;
         rsp_timeout_done_mask  <= tmask;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.is_tick   = (kind_ff == KIND_TICK);
   assign status.scan_last = (rd_idx_ff == IDXW'(TOTAL - 1));
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

endmodule

FILE: src/periodic_and_timeout_timer_bank_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_and_timeout_timer_bank_top
// Bank of periodic and one-shot timeout timers with a shared decrementer.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request per valid/ready handshake: a tick, a start,
//   a stop or a read-and-clear of one slot. Every request gives exactly one
//   response on rsp_bus with the addressed slot's flags and the done masks.
//   The csr_ port sets how many periodic and timeout slots a tick updates.
// Sequencing:
//   Start, stop and clear: the request is latched, executed, then its response is loaded.
//   Tick: the walk reads one slot per cycle through the single count memory
//   port, over all PERIODIC_SLOTS + TIMEOUT_SLOTS slots, finishes the last
//   update and then loads the response. One request is handled at a time;
//   req_bus.ready rises again in the cycle the response turns valid.
// Reset: clears all active and finished flags and the in-use registers;
//   counts and periods are unknown until a start writes them.
// Stall: a held response does not block the next request; that request's
//   response waits until rsp_bus.ready takes the held one.
// ----------------------------------------------------------------------------
module periodic_and_timeout_timer_bank_top
   import ptb_pkg::*;
#(
   parameter int PERIODIC_SLOTS = 8,
   parameter int TIMEOUT_SLOTS  = 8,
   parameter int COUNT_WIDTH    = 16
) (
   input  logic        clock,
   input  logic        reset,
   ptb_req_if.sink     req_bus,
   ptb_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [USE_WIDTH-1:0] periodic_in_use_ff;
   logic [USE_WIDTH-1:0] timeout_in_use_ff;
   logic                 csr_write;
   logic                 csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_in_use_ff <= '0;
         timeout_in_use_ff  <= '0;
      end else if (csr_write) begin
         if (csr_index == REG_PERIODIC_IN_USE) begin
            periodic_in_use_ff <= csr_pwdata[USE_WIDTH-1:0];
         end else begin
            timeout_in_use_ff <= csr_pwdata[USE_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      if (csr_index == REG_PERIODIC_IN_USE) begin
         csr_prdata = 32'(periodic_in_use_ff);
      end else begin
         csr_prdata = 32'(timeout_in_use_ff);
      end
   end

   // controller and datapath
   ctl_cmd_type    ctl_cmd;
   ctl_status_type ctl_status;
   logic           req_ready;

   assign req_bus.ready = req_ready;

   ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .cmd       (ctl_cmd),
      .status    (ctl_status)
   );

   ptb_datapath #(
      .PERIODIC_SLOTS (PERIODIC_SLOTS),
      .TIMEOUT_SLOTS  (TIMEOUT_SLOTS),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (ctl_cmd),
      .status                 (ctl_status),
      .req_kind               (req_bus.kind),
      .req_bank               (req_bus.bank),
      .req_slot               (req_bus.slot),
      .req_load_value         (req_bus.load_value),
      .periodic_in_use        (periodic_in_use_ff),
      .timeout_in_use         (timeout_in_use_ff),
      .rsp_ready              (rsp_bus.ready),
      .rsp_valid              (rsp_bus.valid),
      .rsp_slot_active        (rsp_bus.slot_active),
      .rsp_slot_finished      (rsp_bus.slot_finished),
      .rsp_periodic_done_mask (rsp_bus.periodic_done_mask),
      .rsp_timeout_done_mask  (rsp_bus.timeout_done_mask)
   );

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // a response is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.publish |-> !(rsp_bus.valid && !rsp_bus.ready))
      else $error("response overwritten before being taken");

   // tick walk does not overlap start/stop or response loading
   assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.scan_issue |-> (!ctl_cmd.publish && !ctl_cmd.execute && !req_ready))
      else $error("tick walk overlaps other work");

   // ready returns in the cycle after a response is published
   assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.publish |=> req_ready)
      else $error("controller did not return to idle after response");

endmodule

FILE: dv/periodic_and_timeout_timer_bank_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_and_timeout_timer_bank_top_tb
// Self-checking bench for the periodic / timeout timer bank.
// A short directed table opens the run, then random requests follow over
// several in-use settings and idle/stall mixes. Every request is predicted by
// a behavioral timer-bank model and each response is compared in order.
// ----------------------------------------------------------------------------
module periodic_and_timeout_timer_bank_top_tb;
   import ptb_pkg::*;

   localparam int N_PER       = 8;
   localparam int N_TMO       = 8;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_REQS  = 125;
   localparam int DIR_ROWS    = 16;
   localparam int TICK_LAT    = N_PER + N_TMO + 6;

   typedef struct packed {
      kind_type    kind;
      logic        bank;
      logic [2:0]  slot;
      logic [15:0] load_value;
   } timer_req_type;

   typedef struct packed {
      logic       active;
      logic       finished;
      logic [7:0] periodic_mask;
      logic [7:0] timeout_mask;
   } timer_rsp_type;

   typedef struct packed {
      timer_req_type req;
      logic          typed;
      timer_rsp_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ptb_req_if req_bus ();
   ptb_rsp_if rsp_bus ();

   periodic_and_timeout_timer_bank_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // timer bank shadow state
   logic [15:0] tmr_count  [N_PER + N_TMO];
   logic [15:0] tmr_period [N_PER];
   logic        tmr_active [N_PER + N_TMO];
   logic        tmr_done   [N_PER + N_TMO];
   logic [3:0]  per_in_use;
   logic [3:0]  tmo_in_use;

   timer_rsp_type expected_rsp_q[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches    = 0;
   int rsp_checked   = 0;
   int finish_seen   = 0;
   int kind_count [4];
   int settings_run  = 0;

   // directed table: typed expectations only where obvious
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{'{KIND_TICK,  1'b0, 3'd0, 16'h0000}, 1'b1, '{1'b0, 1'b0, 8'h00, 8'h00}},
      '{'{KIND_CLEAR, 1'b1, 3'd7, 16'hFFFF}, 1'b1, '{1'b0, 1'b0, 8'h00, 8'h00}},
      '{'{KIND_START, 1'b0, 3'd0, 16'h0001}, 1'b1, '{1'b1, 1'b0, 8'h00, 8'h00}},
      '{'{KIND_START, 1'b1, 3'd0, 16'h0001}, 1'b1, '{1'b1, 1'b0, 8'h00, 8'h00}},
      '{'{KIND_START, 1'b0, 3'd7, 16'hFFFF}, 1'b1, '{1'b1, 1'b0, 8'h00, 8'h00}},
      '{'{KIND_START, 1'b1, 3'd7, 16'h0000}, 1'b1, '{1'b1, 1'b0, 8'h00, 8'h00}},
      '{'{KIND_START, 1'b0, 3'd1, 16'h0002}, 1'b1, '{1'b1, 1'b0, 8'h00, 8'h00}},
      '{'{KIND_TICK,  1'b0, 3'd0, 16'h0000}, 1'b0, '0},
      '{'{KIND_TICK,  1'b1, 3'd0, 16'h0000}, 1'b0, '0},
      '{'{KIND_CLEAR, 1'b0, 3'd0, 16'h0000}, 1'b0, '0},
      '{'{KIND_CLEAR, 1'b0, 3'd0, 16'h0000}, 1'b0, '0},
      '{'{KIND_STOP,  1'b0, 3'd1, 16'h0000}, 1'b0, '0},
      '{'{KIND_TICK,  1'b0, 3'd1, 16'h0000}, 1'b0, '0},
      '{'{KIND_START, 1'b0, 3'd1, 16'h0003}, 1'b0, '0},
      '{'{KIND_STOP,  1'b1, 3'd7, 16'hFFFF}, 1'b0, '0},
      '{'{KIND_CLEAR, 1'b1, 3'd0, 16'h0000}, 1'b0, '0}
   };

   // Apply one request to the shadow bank and return its response.
   // The slot field cannot exceed either bank here, so every address is valid.
   function automatic timer_rsp_type advance_timers(timer_req_type r);
      int unsigned   idx;
      int unsigned   n;
      int unsigned   k;
      timer_rsp_type o;
      idx = (r.bank ? N_PER : 0) + r.slot;
      o = '0;
      case (r.kind)
         KIND_TICK: begin
            n = (per_in_use > N_PER) ? N_PER : per_in_use;
            for (int i = 0; i < n; i++) begin
               if (tmr_active[i]) begin
                  tmr_count[i] = tmr_count[i] - 16'd1;
                  if (tmr_count[i] == 16'd0) begin
                     tmr_done[i]  = 1'b1;
                     tmr_count[i] = tmr_period[i];
                  end
               end
            end
            n = (tmo_in_use > N_TMO) ? N_TMO : tmo_in_use;
            for (int i = 0; i < n; i++) begin
               k = N_PER + i;
               if (tmr_active[k]) begin
                  tmr_count[k] = tmr_count[k] - 16'd1;
                  if (tmr_count[k] == 16'd0) begin
                     tmr_done[k]   = 1'b1;
                     tmr_active[k] = 1'b0;
                  end
               end
            end
         end
         KIND_START: begin
            tmr_count[idx] = r.load_value;
            if (!r.bank)
               tmr_period[r.slot] = r.load_value;
            tmr_active[idx] = 1'b1;
            tmr_done[idx]   = 1'b0;
         end
         KIND_STOP: tmr_active[idx] = 1'b0;
         default: ;
      endcase
      // finished is reported before a clear takes effect
      o.finished = tmr_done[idx];
      if (r.kind == KIND_CLEAR)
         tmr_done[idx] = 1'b0;
      o.active = tmr_active[idx];
      for (int i = 0; i < 8; i++) begin
         o.periodic_mask[i] = tmr_done[i];
         o.timeout_mask[i]  = tmr_done[N_PER + i];
      end
      return o;
   endfunction

   // random request, mostly small loads so timers actually expire
   function automatic timer_req_type random_request();
      timer_req_type r;
      int unsigned   pick;
      pick = $urandom_range(99);
      if (pick < 45)
         r.kind = KIND_TICK;
      else if (pick < 70)
         r.kind = KIND_START;
      else if (pick < 78)
         r.kind = KIND_STOP;
      else
         r.kind = KIND_CLEAR;
      r.bank = 1'($urandom_range(1));
      r.slot = 3'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 65)
         r.load_value = 16'($urandom_range(8, 1));
      else if (pick < 75)
         r.load_value = 16'h0000;
      else if (pick < 85)
         r.load_value = 16'hFFFF - 16'($urandom_range(3));
      else
         r.load_value = 16'($urandom);
      return r;
   endfunction

   // Drive one request, wait for acceptance, queue its predicted response.
   // valid stays high between back-to-back requests.
   task automatic issue_request(input timer_req_type r, input logic typed,
                                input timer_rsp_type want);
      timer_rsp_type model_rsp;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= r.kind;
      req_bus.bank       <= r.bank;
      req_bus.slot       <= r.slot;
      req_bus.load_value <= r.load_value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      model_rsp = advance_timers(r);
      expected_rsp_q.push_back(typed ? want : model_rsp);
      kind_count[r.kind]++;
   endtask

   // drop valid and hold off until every outstanding response is back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle
   task automatic csr_write(input logic reg_idx, input logic [3:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= {28'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_idx == REG_PERIODIC_IN_USE)
         per_in_use = value;
      else
         tmo_in_use = value;
   endtask

   // APB read-back of an in-use register
   task automatic csr_check(input logic reg_idx, input logic [3:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[USE_WIDTH-1:0] !== value) begin
         mismatches++;
         if (mismatches <= 10)
            $display("csr read mismatch reg %0d: expected %0d got %0d",
                     reg_idx, value, csr_prdata[USE_WIDTH-1:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_in_use(input logic [3:0] per, input logic [3:0] tmo);
      csr_write(REG_PERIODIC_IN_USE, per);
      csr_write(REG_TIMEOUT_IN_USE, tmo);
      csr_check(REG_PERIODIC_IN_USE, per);
      csr_check(REG_TIMEOUT_IN_USE, tmo);
      settings_run++;
   endtask

   task automatic report_mismatch(input timer_rsp_type want, input timer_rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"rsp mismatch @%0t: exp act=%0d fin=%0d pm=%02h tm=%02h",
                   "  got act=%0d fin=%0d pm=%02h tm=%02h"},
                  $realtime, want.active, want.finished, want.periodic_mask,
                  want.timeout_mask, got.active, got.finished, got.periodic_mask,
                  got.timeout_mask);
   endtask

   // response monitor and random receiver stall
   always @(posedge clock) begin
      timer_rsp_type got;
      timer_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = {rsp_bus.slot_active, rsp_bus.slot_finished,
                rsp_bus.periodic_done_mask, rsp_bus.timeout_done_mask};
         if (expected_rsp_q.size() == 0) begin
            report_mismatch('x, got);
         end else begin
            want = expected_rsp_q.pop_front();
            rsp_checked++;
            if (want.finished)
               finish_seen++;
            if (got.active !== want.active || got.finished !== want.finished ||
                got.periodic_mask !== want.periodic_mask ||
                got.timeout_mask !== want.timeout_mask)
               report_mismatch(want, got);
         end
      end
      rsp_bus.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   // run limit
   initial begin
      #5_000_000;
      $display("timeout waiting for responses");
      $display("periodic_and_timeout_timer_bank_top_tb NOT OK");
      $finish;
   end

   // main sequence
   initial begin
      logic [3:0] per_cfg;
      logic [3:0] tmo_cfg;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_TICK;
      req_bus.bank       = 1'b0;
      req_bus.slot       = 3'd0;
      req_bus.load_value = 16'h0000;
      rsp_bus.ready      = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = 3'd0;
      csr_pwdata         = 32'd0;
      per_in_use         = 4'd0;
      tmo_in_use         = 4'd0;
      for (int i = 0; i < N_PER + N_TMO; i++) begin
         tmr_count[i]  = 16'd0;
         tmr_active[i] = 1'b0;
         tmr_done[i]   = 1'b0;
      end
      for (int i = 0; i < N_PER; i++)
         tmr_period[i] = 16'd0;
      for (int i = 0; i < 4; i++)
         kind_count[i] = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with both banks fully scanned
      program_in_use(4'd8, 4'd8);
      for (int i = 0; i < DIR_ROWS; i++)
         issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      drain_responses();

      // random phases: in-use extremes and saturation, rotating idle and stall mixes
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: begin per_cfg = 4'd8;  tmo_cfg = 4'd8;  end
            1: begin per_cfg = 4'd15; tmo_cfg = 4'd3;  end
            2: begin per_cfg = 4'd0;  tmo_cfg = 4'd8;  end
            3: begin per_cfg = 4'd5;  tmo_cfg = 4'd15; end
            4: begin per_cfg = 4'd8;  tmo_cfg = 4'd0;  end
            6: begin per_cfg = 4'd9;  tmo_cfg = 4'd1;  end
            default: begin
               per_cfg = 4'($urandom_range(15));
               tmo_cfg = 4'($urandom_range(15));
            end
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         program_in_use(per_cfg, tmo_cfg);
         for (int n = 0; n < PHASE_REQS; n++) begin
            issue_request(random_request(), 1'b0, '0);
            // occasional full stop of the sender mid-phase
            if ($urandom_range(39) == 0)
               drain_responses();
         end
         drain_responses();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (TICK_LAT) @(posedge clock);

      $display("ran %0d ticks, %0d starts, %0d stops, %0d clears over %0d in-use settings",
               kind_count[KIND_TICK], kind_count[KIND_START], kind_count[KIND_STOP],
               kind_count[KIND_CLEAR], settings_run);
      $display("checked %0d responses, %0d reporting a finished slot, %0d mismatches",
               rsp_checked, finish_seen, mismatches);
      if (mismatches == 0 && expected_rsp_q.size() == 0)
         $display("periodic_and_timeout_timer_bank_top_tb OK");
      else
         $display("periodic_and_timeout_timer_bank_top_tb NOT OK");
      $finish;
   end

endmodule
